// File: rtl/sct_pkg.sv
// Shared types and constants of the source code tokenizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package sct_pkg;

  localparam int unsigned OFFSET_BITS = 24;
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  // token kinds
  localparam logic [3:0] K_LPAREN   = 4'd0;
  localparam logic [3:0] K_RPAREN   = 4'd1;
  localparam logic [3:0] K_LBRACE   = 4'd2;
  localparam logic [3:0] K_RBRACE   = 4'd3;
  localparam logic [3:0] K_LBRACK   = 4'd4;
  localparam logic [3:0] K_RBRACK   = 4'd5;
  localparam logic [3:0] K_SEMI     = 4'd6;
  localparam logic [3:0] K_DASH_BAR = 4'd7;
  localparam logic [3:0] K_BAR_DASH = 4'd8;
  localparam logic [3:0] K_COMMA    = 4'd9;
  localparam logic [3:0] K_STRING   = 4'd10;
  localparam logic [3:0] K_SPACE    = 4'd11;
  localparam logic [3:0] K_OPER     = 4'd12;
  localparam logic [3:0] K_NUM      = 4'd13;
  localparam logic [3:0] K_SYM      = 4'd14;
  localparam logic [3:0] K_ERROR    = 4'd15;

  // diagnostics
  localparam logic [1:0] D_NONE    = 2'd0;
  localparam logic [1:0] D_UNEXP   = 2'd1;
  localparam logic [1:0] D_CUT_NL  = 2'd2;
  localparam logic [1:0] D_CUT_END = 2'd3;

  // open quote
  localparam logic [1:0] Q_NONE   = 2'd0;
  localparam logic [1:0] Q_SINGLE = 2'd1;
  localparam logic [1:0] Q_DOUBLE = 2'd2;
  localparam logic [1:0] Q_BACK   = 2'd3;

  typedef struct packed {
    logic [3:0]             kind;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] len;
    logic [1:0]             diag;
    logic                   last;
  } tok_t;

  // Tokens produced by one item, lowest slots first.
  typedef struct packed {
    logic [CNT_W-1:0]             cnt;
    tok_t [MAX_RESULTS-1:0]       toks;
  } push_t;

endpackage

`default_nettype wire

// File: rtl/source_code_tokenizer_top.sv
// Top level of the streaming source code tokenizer.
// Depends on sct_pkg, sct_lexer and sct_res_fifo.
//
// Source bytes enter on the in_* channel, one item per byte, with
// final_byte_i set on the last byte of a source. Tokens leave on the out_*
// channel as kind, start offset, length and diagnostic; run_last_o marks the
// last token caused by one byte. A byte may cause zero to three tokens.
// A byte accepted into the input register is lexed while it is held there, and its
// tokens are written into the queue once the queue has room. Throughput is
// one byte per cycle while the bytes cause at most one token each and the
// receiver is ready; the output side moves one token per cycle, so bytes that
// cause more tokens hold the input back.
// Lexing is done in one pass between the input register and a four-entry
// result queue; a held byte is lexed while the queue has room for three more
// tokens, independent of out_ready_i in the same cycle.
// Reset empties the queue, drops any held byte and returns the lexer to an
// idle state at offset zero. When the receiver stalls, the head token holds
// and, once two tokens wait with a byte held, in_ready_o drops. After a final
// byte the next byte starts a new source at offset zero.
`default_nettype none

module source_code_tokenizer_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [7:0]                      source_byte_i,
  input  wire logic                            final_byte_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [3:0]                           token_kind_o,
  output logic [sct_pkg::OFFSET_BITS-1:0]      start_offset_o,
  output logic [sct_pkg::OFFSET_BITS-1:0]      token_length_o,
  output logic [1:0]                           diagnostic_o,
  output logic                                 run_last_o
);
  import sct_pkg::*;

  push_t push;
  tok_t  head;
  logic  room;

  sct_lexer u_lexer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .source_byte_i (source_byte_i),
    .final_byte_i  (final_byte_i),
    .room_i        (room),
    .push_o        (push)
  );

  sct_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign token_kind_o   = head.kind;
  assign start_offset_o = head.start;
  assign token_length_o = head.len;
  assign diagnostic_o   = head.diag;
  assign run_last_o     = head.last;

endmodule

`default_nettype wire

// File: rtl/sct_lexer.sv
// Input register, lexer state and the per-item token logic.
// Depends on sct_pkg; feeds the result queue (sct_res_fifo).
`default_nettype none

module sct_lexer (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    source_byte_i,
  input  wire logic          final_byte_i,
  input  wire logic          room_i,
  output sct_pkg::push_t     push_o
);
  import sct_pkg::*;

  localparam logic [3:0] M_IDLE     = 4'd0;
  localparam logic [3:0] M_PEND     = 4'd1;
  localparam logic [3:0] M_WS       = 4'd2;
  localparam logic [3:0] M_WS_SLASH = 4'd3;
  localparam logic [3:0] M_BLOCK    = 4'd4;
  localparam logic [3:0] M_LINE     = 4'd5;
  localparam logic [3:0] M_STR      = 4'd6;
  localparam logic [3:0] M_OPER     = 4'd7;
  localparam logic [3:0] M_NUM      = 4'd8;
  localparam logic [3:0] M_SYM      = 4'd9;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_RESULTS);

  typedef struct packed {
    logic [3:0]             mode;
    logic [7:0]             pend;
    logic [1:0]             quote;
    logic                   star;
    logic [OFFSET_BITS-1:0] tstart;
    logic [OFFSET_BITS-1:0] pos;
    logic [OFFSET_BITS-1:0] slash;
  } lex_state_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_sym(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           is_digit(c) || (c == 8'h5F);
  endfunction

  // ASCII operator bytes plus the UTF-8 bytes of the special symbols
  function automatic logic is_op(input logic [7:0] c);
    logic r;
    case (c)
      8'h2D, 8'h2B, 8'h26, 8'h23, 8'h40, 8'h3C, 8'h3E, 8'h5E, 8'h7E, 8'h25,
      8'h7C, 8'h3D, 8'h24, 8'h5C, 8'h2F, 8'h2A, 8'h3A, 8'h3F, 8'h21, 8'h2E,
      8'hE2, 8'h88, 8'h86, 8'h80, 8'hA2, 8'hC3, 8'hB7, 8'h97, 8'hC2, 8'hB0:
        r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] quote_char(input logic [1:0] q);
    return (q == Q_SINGLE) ? CH_SQUOTE : ((q == Q_DOUBLE) ? CH_DQUOTE : CH_BTICK);
  endfunction

  function automatic logic [3:0] run_kind_of(input logic [3:0] mode);
    return (mode == M_OPER) ? K_OPER : ((mode == M_NUM) ? K_NUM : K_SYM);
  endfunction

  // Length from a to the exclusive end e, at least one, saturating.
  function automatic logic [OFFSET_BITS-1:0] span(input logic [OFFSET_BITS-1:0] a,
                                                 input logic [OFFSET_BITS:0]   e);
    logic [OFFSET_BITS:0]   d;
    logic [OFFSET_BITS-1:0] r;
    d = e - {1'b0, a};
    if (e <= {1'b0, a}) begin
      r = {{(OFFSET_BITS-1){1'b0}}, 1'b1};
    end else if (d[OFFSET_BITS]) begin
      r = OFF_MAX;
    end else begin
      r = d[OFFSET_BITS-1:0];
    end
    return r;
  endfunction

  function automatic tok_t mk_tok(input logic [3:0] kind, input logic [OFFSET_BITS-1:0] st,
                                  input logic [OFFSET_BITS-1:0] len, input logic [1:0] diag);
    tok_t t;
    t.kind  = kind;
    t.start = st;
    t.len   = len;
    t.diag  = diag;
    t.last  = 1'b0;
    return t;
  endfunction

  logic                   vld_q, vld_d;
  logic [7:0]             byte_q;
  logic                   fin_q;
  lex_state_t             st_q, st_d;
  logic                   accept, process;

  lex_state_t             s;
  tok_t [MAX_RESULTS-1:0] res;
  logic [CNT_W-1:0]       n;
  logic                   run_f, begin_f, in_run, fixed_hit;
  logic [3:0]             run_kind, fixed_kind;
  logic [7:0]             c;
  logic [OFFSET_BITS-1:0] p;
  logic [OFFSET_BITS:0]   p_ext, p1;

  assign in_ready_o = !vld_q || room_i;
  assign accept     = in_valid_i && in_ready_o;
  assign process    = vld_q && room_i;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (process) begin
      vld_d = 1'b0;
    end
  end

  always_comb begin
    s          = st_q;
    res        = '0;
    n          = '0;
    run_f      = 1'b0;
    begin_f    = 1'b0;
    in_run     = 1'b0;
    run_kind   = K_SYM;
    fixed_hit  = 1'b0;
    fixed_kind = K_LPAREN;
    c          = byte_q;
    p          = st_q.pos;
    p_ext      = {1'b0, p};
    p1         = p_ext + 1'b1;

    // lexer step for the current mode
    unique case (s.mode)
      M_PEND: begin
        if (s.pend == CH_DASH && c == CH_BAR) begin
          res[n] = mk_tok(K_DASH_BAR, s.tstart, span(s.tstart, p1), D_NONE);
          n = n + 1'b1;
          s.mode = M_IDLE;
        end else if (s.pend == CH_BAR && c == CH_DASH) begin
          res[n] = mk_tok(K_BAR_DASH, s.tstart, span(s.tstart, p1), D_NONE);
          n = n + 1'b1;
          s.mode = M_IDLE;
        end else begin
          s.mode = M_OPER;
          run_f  = 1'b1;
        end
      end
      M_WS: begin
        if (is_ws(c)) begin
          s.mode = M_WS;
        end else if (c == CH_HASH) begin
          s.mode = M_LINE;
        end else if (c == CH_SLASH) begin
          s.mode  = M_WS_SLASH;
          s.slash = p;
        end else begin
          res[n] = mk_tok(K_SPACE, s.tstart, span(s.tstart, p_ext), D_NONE);
          n = n + 1'b1;
          begin_f = 1'b1;
        end
      end
      M_WS_SLASH: begin
        if (c == CH_STAR) begin
          s.mode = M_BLOCK;
          s.star = 1'b0;
        end else if (c == CH_SLASH) begin
          s.mode = M_LINE;
        end else begin
          if (s.slash > s.tstart) begin
            res[n] = mk_tok(K_SPACE, s.tstart, span(s.tstart, {1'b0, s.slash}), D_NONE);
            n = n + 1'b1;
          end
          s.tstart = s.slash;
          s.mode   = M_OPER;
          run_f    = 1'b1;
        end
      end
      M_BLOCK: begin
        if (c == CH_SLASH && s.star) begin
          res[n] = mk_tok(K_SPACE, s.tstart, span(s.tstart, p1), D_NONE);
          n = n + 1'b1;
          s.mode = M_IDLE;
        end else begin
          s.star = (c == CH_STAR);
        end
      end
      M_LINE: begin
        if (c == CH_LF) begin
          res[n] = mk_tok(K_SPACE, s.tstart, span(s.tstart, p_ext), D_NONE);
          n = n + 1'b1;
          begin_f = 1'b1;
        end
      end
      M_STR: begin
        if (c == quote_char(s.quote)) begin
          res[n] = mk_tok(K_STRING, s.tstart, span(s.tstart, p1), D_NONE);
          n = n + 1'b1;
          s.mode = M_IDLE;
        end else if (c == CH_LF && s.quote != Q_DOUBLE) begin
          res[n] = mk_tok(K_STRING, s.tstart, span(s.tstart, p1), D_CUT_NL);
          n = n + 1'b1;
          s.mode = M_IDLE;
        end
      end
      M_OPER, M_NUM, M_SYM: run_f = 1'b1;
      default: begin_f = 1'b1;
    endcase

    // greedy run: close it on the first byte outside its class
    if (run_f) begin
      unique case (s.mode)
        M_OPER: begin
          in_run   = is_op(c);
          run_kind = K_OPER;
        end
        M_NUM: begin
          in_run   = is_digit(c) || (c == CH_DOT);
          run_kind = K_NUM;
        end
        default: begin
          in_run   = is_sym(c);
          run_kind = K_SYM;
        end
      endcase
      if (!in_run) begin
        res[n] = mk_tok(run_kind, s.tstart, span(s.tstart, p_ext), D_NONE);
        n = n + 1'b1;
        begin_f = 1'b1;
      end
    end

    // token start
    if (begin_f) begin
      s.mode   = M_IDLE;
      s.tstart = p;
      unique case (c)
        CH_LPAREN: begin fixed_hit = 1'b1; fixed_kind = K_LPAREN; end
        CH_RPAREN: begin fixed_hit = 1'b1; fixed_kind = K_RPAREN; end
        CH_LBRACE: begin fixed_hit = 1'b1; fixed_kind = K_LBRACE; end
        CH_RBRACE: begin fixed_hit = 1'b1; fixed_kind = K_RBRACE; end
        CH_LBRACK: begin fixed_hit = 1'b1; fixed_kind = K_LBRACK; end
        CH_RBRACK: begin fixed_hit = 1'b1; fixed_kind = K_RBRACK; end
        CH_SEMI:   begin fixed_hit = 1'b1; fixed_kind = K_SEMI;   end
        CH_COMMA:  begin fixed_hit = 1'b1; fixed_kind = K_COMMA;  end
        default:   fixed_hit = 1'b0;
      endcase
      priority if (fixed_hit) begin
        if (n != CNT_FULL) begin
          res[n] = mk_tok(fixed_kind, p, {{(OFFSET_BITS-1){1'b0}}, 1'b1}, D_NONE);
          n = n + 1'b1;
        end
      end else if (c == CH_DASH || c == CH_BAR) begin
        s.mode = M_PEND;
        s.pend = c;
      end else if (c == CH_SQUOTE) begin
        s.mode  = M_STR;
        s.quote = Q_SINGLE;
      end else if (c == CH_DQUOTE) begin
        s.mode  = M_STR;
        s.quote = Q_DOUBLE;
      end else if (c == CH_BTICK) begin
        s.mode  = M_STR;
        s.quote = Q_BACK;
      end else if (is_ws(c)) begin
        s.mode = M_WS;
      end else if (c == CH_HASH) begin
        s.mode = M_LINE;
      end else if (c == CH_SLASH) begin
        s.mode  = M_WS_SLASH;
        s.slash = p;
      end else if (is_op(c)) begin
        s.mode = M_OPER;
      end else if (is_digit(c)) begin
        s.mode = M_NUM;
      end else if (is_sym(c)) begin
        s.mode = M_SYM;
      end else begin
        if (n != CNT_FULL) begin
          res[n] = mk_tok(K_ERROR, p, {{(OFFSET_BITS-1){1'b0}}, 1'b1}, D_UNEXP);
          n = n + 1'b1;
        end
      end
    end

    // end of source: flush the open token, then start afresh
    if (fin_q) begin
      unique case (s.mode)
        M_PEND: begin
          if (n != CNT_FULL) begin
            res[n] = mk_tok(K_OPER, s.tstart, {{(OFFSET_BITS-1){1'b0}}, 1'b1}, D_NONE);
            n = n + 1'b1;
          end
        end
        M_WS, M_LINE, M_BLOCK: begin
          if (n != CNT_FULL) begin
            res[n] = mk_tok(K_SPACE, s.tstart, span(s.tstart, p1), D_NONE);
            n = n + 1'b1;
          end
        end
        M_WS_SLASH: begin
          if (s.slash > s.tstart && n != CNT_FULL) begin
            res[n] = mk_tok(K_SPACE, s.tstart, span(s.tstart, {1'b0, s.slash}), D_NONE);
            n = n + 1'b1;
          end
          if (n != CNT_FULL) begin
            res[n] = mk_tok(K_OPER, s.slash, {{(OFFSET_BITS-1){1'b0}}, 1'b1}, D_NONE);
            n = n + 1'b1;
          end
        end
        M_STR: begin
          if (n != CNT_FULL) begin
            res[n] = mk_tok(K_STRING, s.tstart, span(s.tstart, p1), D_CUT_END);
            n = n + 1'b1;
          end
        end
        M_OPER, M_NUM, M_SYM: begin
          if (n != CNT_FULL) begin
            res[n] = mk_tok(run_kind_of(s.mode), s.tstart, span(s.tstart, p1), D_NONE);
            n = n + 1'b1;
          end
        end
        default: s.mode = M_IDLE;
      endcase
      s = '0;
    end else if (p != OFF_MAX) begin
      s.pos = p + 1'b1;
    end

    if (n != '0) begin
      res[n - 1'b1].last = 1'b1;
    end
  end

  assign st_d        = process ? s : st_q;
  assign push_o.cnt  = process ? n : '0;
  assign push_o.toks = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      st_q  <= '0;
    end else begin
      vld_q <= vld_d;
      st_q  <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= source_byte_i;
      fin_q  <= final_byte_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sct_res_fifo.sv
// Result queue: takes up to three tokens per cycle, hands out one.
// Depends on sct_pkg; written by sct_lexer.
`default_nettype none

module sct_res_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  sct_pkg::push_t      push_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output sct_pkg::tok_t       head_o
);
  import sct_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  tok_t          mem [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign head_o      = mem[rd_q];
  assign room_o      = (cnt_q <= CW'(DEPTH - MAX_RESULTS));

  assign wr_d  = wr_q + AW'(push_i.cnt);
  assign rd_d  = rd_q + AW'(pop);
  assign cnt_d = cnt_q + CW'(push_i.cnt) - CW'(pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (CW'(i) < CW'(push_i.cnt)) begin
        mem[wr_q + AW'(i)] <= push_i.toks[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sct_checker.sv
// Port-level checks of the tokenizer, bound to source_code_tokenizer_top.
// Depends on sct_pkg for the offset width and the token codes.
`default_nettype none

module sct_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire logic [7:0]                 source_byte_i,
  input wire logic                       final_byte_i,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic [3:0]                 token_kind_o,
  input wire logic [sct_pkg::OFFSET_BITS-1:0] start_offset_o,
  input wire logic [sct_pkg::OFFSET_BITS-1:0] token_length_o,
  input wire logic [1:0]                 diagnostic_o,
  input wire logic                       run_last_o
);
  import sct_pkg::*;

  // stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_kind_o) &&
      $stable(start_offset_o) && $stable(token_length_o) &&
      $stable(diagnostic_o) && $stable(run_last_o))
    else $error("output item changed while stalled");

  // input back-pressure only while results wait
  a_bp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_length_o != '0)
    else $error("zero token length");

  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((token_kind_o == K_ERROR) == (diagnostic_o == D_UNEXP)))
    else $error("error kind and diagnostic disagree");

  a_cut: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (diagnostic_o == D_CUT_NL || diagnostic_o == D_CUT_END) |->
      token_kind_o == K_STRING)
    else $error("cut diagnostic on a non-string token");

endmodule

bind source_code_tokenizer_top sct_checker u_sct_checker (.*);

`default_nettype wire
